// ===== rtl/cnr_pkg.sv =====
// Shared types and constants for the curve number runoff pipeline.
// Used by cnr_mid and curve_number_runoff.
package cnr_pkg;
	localparam int RAIN_W = 24;
	localparam int CN_W   = 16;
	localparam int FR_W   = 26;
	localparam int S_W    = 31;
	localparam int NUM_W  = 52;
	localparam int DEN_W  = 31;
	localparam int QR_W   = 23;

	localparam logic [30:0] K_25400_Q16 = 31'd1664614400;
	localparam logic [30:0] K_254_Q8    = 31'd65024;
	localparam logic [14:0] CN_MAX_Q8   = 15'd25600;
	localparam logic [23:0] NO_DATA_RST = 24'hD8F100;

	typedef struct packed {
		logic             nd;
		logic             zero;
		logic [QR_W-1:0]  r;
	} cell_sb_t;
endpackage

// ===== rtl/cnr_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Generic; no package dependencies.
module cnr_div_pipe #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 15,
	parameter int Q_W   = 31,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [SB_W-1:0]  sb_in,
	output logic             out_valid,
	output logic [Q_W-1:0]   quo,
	output logic [SB_W-1:0]  sb_out
);
	logic             vld_s  [Q_W+1];
	logic [DEN_W-1:0] rem_s  [Q_W+1];
	logic [Q_W-1:0]   work_s [Q_W+1];
	logic [DEN_W-1:0] den_s  [Q_W+1];
	logic [SB_W-1:0]  sb_s   [Q_W+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = DEN_W'(num[NUM_W-1:Q_W]);
	assign work_s[0] = num[Q_W-1:0];
	assign den_s[0]  = den;
	assign sb_s[0]   = sb_in;

	for (genvar i = 0; i < Q_W; i++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;
		always_comb begin
			trial = {rem_s[i], work_s[i][Q_W-1]};
			diff  = trial - {1'b0, den_s[i]};
			ge    = !diff[DEN_W];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			work_s[i+1] <= {work_s[i][Q_W-2:0], ge};
			den_s[i+1]  <= den_s[i];
			sb_s[i+1]   <= sb_s[i];
		end
	end

	assign out_valid = vld_s[Q_W];
	assign quo       = work_s[Q_W];
	assign sb_out    = sb_s[Q_W];
endmodule

// ===== rtl/cnr_mid.sv =====
// Middle stages: retention, excess rainfall, squared numerator and denominator.
// Depends on cnr_pkg.
module cnr_mid import cnr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [S_W-1:0]   q,
	input  cell_sb_t         sb_in,
	output logic             out_valid,
	output logic [NUM_W-1:0] num,
	output logic [DEN_W-1:0] den,
	output logic             nd
);
	logic [S_W-1:0]  s_c;
	logic [FR_W-1:0] fr_c;
	logic            kill_c;

	logic            v_s1, nd_s1, kill_s1;
	logic [FR_W-1:0] fr_s1;
	logic [FR_W-1:0] s_s1;

	logic [FR_W-1:0] d_c;
	logic [28:0]     sum_c;

	logic             v_s2, nd_s2;
	logic [NUM_W-1:0] num_s2;
	logic [DEN_W-1:0] den_s2;

	always_comb begin
		s_c    = q - K_254_Q8;
		fr_c   = FR_W'({3'b000, sb_in.r} * 26'd5);
		kill_c = sb_in.zero || ({5'b0, fr_c} <= s_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		d_c   = fr_s1 - s_s1;
		sum_c = 29'(fr_s1) + {1'b0, s_s1, 2'b00};
	end

	always_ff @(posedge clk) begin
		nd_s1   <= sb_in.nd;
		kill_s1 <= kill_c;
		fr_s1   <= fr_c;
		s_s1    <= s_c[FR_W-1:0];
		nd_s2   <= nd_s1;
		if (kill_s1) begin
			num_s2 <= '0;
			den_s2 <= DEN_W'(1);
		end else begin
			num_s2 <= {26'b0, d_c} * {26'b0, d_c};
			den_s2 <= {sum_c, 2'b00} + {2'b00, sum_c};
		end
	end

	assign out_valid = v_s2;
	assign num       = num_s2;
	assign den       = den_s2;
	assign nd        = nd_s2;
endmodule

// ===== rtl/curve_number_runoff.sv =====
// Top level of the SCS curve number runoff pipeline with its APB register.
// Depends on cnr_pkg, cnr_div_pipe and cnr_mid.
//
// One cell enters on every clock where start is high; busy is always low. Each
// result appears on runoff_mm and is_no_data with done high for one cycle,
// after passing through one input stage, a 31-stage retention divider, two
// stages for the squared excess and denominator, a 23-stage runoff divider and
// one output stage. Results leave in input order.
module curve_number_runoff import cnr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [RAIN_W-1:0] rainfall_mm,
	input  logic signed [CN_W-1:0]   cn_value,
	output logic                     done,
	output logic signed [RAIN_W-1:0] runoff_mm,
	output logic                     is_no_data
);
	logic [RAIN_W-1:0] no_data_q;

	logic        v_s1;
	cell_sb_t    sb_s1;
	logic [14:0] c_s1;

	logic        d1_valid;
	logic [30:0] d1_q;
	cell_sb_t    d1_sb;

	logic             m_valid, m_nd;
	logic [NUM_W-1:0] m_num;
	logic [DEN_W-1:0] m_den;

	logic            d2_valid;
	logic [QR_W-1:0] d2_q;
	logic            d2_nd;

	logic                     done_q, nd_q;
	logic [RAIN_W-1:0]        runoff_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign prdata = paddr[2] ? 32'd0 : {{8{no_data_q[RAIN_W-1]}}, no_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_data_q <= NO_DATA_RST;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			no_data_q <= pwdata[RAIN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			done_q <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		sb_s1.nd   <= rainfall_mm[RAIN_W-1] || cn_value[CN_W-1];
		sb_s1.zero <= (cn_value == '0) || (rainfall_mm == '0);
		sb_s1.r    <= rainfall_mm[QR_W-1:0];
		if (cn_value[14:0] > CN_MAX_Q8) begin
			c_s1 <= CN_MAX_Q8;
		end else if (cn_value[14:0] == 15'd0) begin
			c_s1 <= 15'd1;
		end else begin
			c_s1 <= cn_value[14:0];
		end
	end

	cnr_div_pipe #(
		.NUM_W(32), .DEN_W(15), .Q_W(31), .SB_W($bits(cell_sb_t))
	) u_div_ret (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s1), .num({1'b0, K_25400_Q16}), .den(c_s1), .sb_in(sb_s1),
		.out_valid(d1_valid), .quo(d1_q), .sb_out(d1_sb)
	);

	cnr_mid u_mid (
		.clk(clk), .arst_n(arst_n),
		.in_valid(d1_valid), .q(d1_q), .sb_in(d1_sb),
		.out_valid(m_valid), .num(m_num), .den(m_den), .nd(m_nd)
	);

	cnr_div_pipe #(
		.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(QR_W), .SB_W(1)
	) u_div_run (
		.clk(clk), .arst_n(arst_n),
		.in_valid(m_valid), .num(m_num), .den(m_den), .sb_in(m_nd),
		.out_valid(d2_valid), .quo(d2_q), .sb_out(d2_nd)
	);

	always_ff @(posedge clk) begin
		nd_q     <= d2_nd;
		runoff_q <= d2_nd ? no_data_q : {1'b0, d2_q};
	end

	assign done       = done_q;
	assign runoff_mm  = runoff_q;
	assign is_no_data = nd_q;
endmodule
